// ===== hdl/fips_pkg.sv =====
// ============================================================================
// fips_pkg
// Shared widths, register and sector codes, sine table builder and the word
// types passed between the stages of the inverse Park / SVPWM core.
// ============================================================================
package fips_pkg;

    localparam int ANGLE_W   = 12;
    localparam int VOLT_W    = 16;
    localparam int TRIG_W    = 17;   // signed Q1.15, +-1.0 inclusive
    localparam int MAG_W     = 16;   // unsigned table entry, 0..32768
    localparam int ROM_DEPTH = 1025; // quarter wave plus the end point
    localparam int ROM_AW    = 11;
    localparam int PP_W      = 6;
    localparam int PROD_W    = 33;
    localparam int AL_W      = 18;
    localparam int A3_W      = 20;
    localparam int SP_W      = 36;
    localparam int NUM_W     = 40;
    localparam int MAGN_W    = 39;
    localparam int LO_W      = 20;
    localparam int DIVD_W    = 37;
    localparam int QUO_W     = 17;
    localparam int REM_W     = 33;
    localparam int CMP_W     = 16;
    localparam int CODE_W    = 3;
    localparam int LANES     = 3;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 16;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 64;

    localparam logic [CFG_AW-1:0] CFG_ENC_ZERO   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_POLE_PAIRS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SUPPLY     = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_PERIOD     = 2'd3;

    localparam logic [11:0] ENC_ZERO_RST   = 12'd0;
    localparam logic [5:0]  POLE_PAIRS_RST = 6'd7;
    localparam logic [15:0] SUPPLY_RST     = 16'd3072;
    localparam logic [15:0] PERIOD_RST     = 16'd1800;

    localparam logic [CODE_W-1:0] SEC1 = 3'd1;
    localparam logic [CODE_W-1:0] SEC2 = 3'd2;
    localparam logic [CODE_W-1:0] SEC3 = 3'd3;
    localparam logic [CODE_W-1:0] SEC4 = 3'd4;
    localparam logic [CODE_W-1:0] SEC5 = 3'd5;
    localparam logic [CODE_W-1:0] SEC6 = 3'd6;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

    typedef logic [MAG_W-1:0] sine_rom_t [0:ROM_DEPTH-1];

    // Q30 Taylor series, eight correction terms, rounded to Q1.15
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        x    = (64'(idx) * HALF_PI_Q30) >> 10;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            term = (term * x2) >> 30;
            case (k)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                6: term = term / 156;
                7: term = term / 210;
                default: term = term / 272;
            endcase
            if ((k % 2) == 1) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        v = (sum + 64'sd16384) >>> 15;
        if (v > 64'sd32768) v = 64'sd32768;
        return v[MAG_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    typedef struct packed {
        logic [ANGLE_W-1:0]       elec;
        logic signed [VOLT_W-1:0] vd;
        logic signed [VOLT_W-1:0] vq;
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } trig_word_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]     elec;
        logic signed [AL_W-1:0] bt;
        logic signed [A3_W-1:0] a3;
        logic signed [SP_W-1:0] sa;
        logic signed [SP_W-1:0] sb;
    } park_word_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]             elec;
        logic [CODE_W-1:0]              code;
        logic [LANES-1:0]               neg;
        logic [LANES-1:0][DIVD_W-1:0]   num;
    } div_in_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]             elec;
        logic [CODE_W-1:0]              code;
        logic [LANES-1:0]               neg;
        logic [LANES-1:0]               ovf;
        logic [LANES-1:0][REM_W-1:0]    rem;
        logic [LANES-1:0][QUO_W-1:0]    quo;
    } div_word_t;

endpackage

// ===== hdl/fips_trig.sv =====
// ============================================================================
// fips_trig
// Electrical angle and signed sine/cosine from the quarter-wave table.
// ============================================================================
module fips_trig (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [fips_pkg::ANGLE_W-1:0]        raw_angle,
    input  logic signed [fips_pkg::VOLT_W-1:0]  volt_d,
    input  logic signed [fips_pkg::VOLT_W-1:0]  volt_q,
    input  logic [fips_pkg::ANGLE_W-1:0]        encoder_zero,
    input  logic [fips_pkg::PP_W-1:0]           pole_pairs,
    output logic                                out_valid,
    output fips_pkg::trig_word_t                out_word
);
    import fips_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [3:0] v_reg;

    // stage 1: electrical angle
    logic [ANGLE_W-1:0]       mech;
    logic [17:0]              elec_prod;
    logic [ANGLE_W-1:0]       elec1_reg;
    logic signed [VOLT_W-1:0] vd1_reg, vq1_reg;

    assign mech      = raw_angle - encoder_zero;
    assign elec_prod = 18'(mech) * 18'(pole_pairs);

    // stage 2: table addresses
    logic [1:0]               quad_s, quad_c;
    logic [ROM_AW-1:0]        addr_s_next, addr_c_next;
    logic [ROM_AW-1:0]        addr_s2_reg, addr_c2_reg;
    logic                     neg_s2_reg, neg_c2_reg;
    logic [ANGLE_W-1:0]       elec2_reg;
    logic signed [VOLT_W-1:0] vd2_reg, vq2_reg;

    assign quad_s      = elec1_reg[11:10];
    assign quad_c      = quad_s + 2'd1;
    assign addr_s_next = quad_s[0] ? (11'd1024 - {1'b0, elec1_reg[9:0]})
                                   : {1'b0, elec1_reg[9:0]};
    assign addr_c_next = quad_c[0] ? (11'd1024 - {1'b0, elec1_reg[9:0]})
                                   : {1'b0, elec1_reg[9:0]};

    // stage 3: table read
    logic [MAG_W-1:0]         mag_s3_reg, mag_c3_reg;
    logic                     neg_s3_reg, neg_c3_reg;
    logic [ANGLE_W-1:0]       elec3_reg;
    logic signed [VOLT_W-1:0] vd3_reg, vq3_reg;

    // stage 4: apply quadrant sign
    trig_word_t               word_next, word4_reg;
    logic signed [TRIG_W-1:0] smag, cmag;

    assign smag = $signed({1'b0, mag_s3_reg});
    assign cmag = $signed({1'b0, mag_c3_reg});

    always_comb begin
        word_next.elec  = elec3_reg;
        word_next.vd    = vd3_reg;
        word_next.vq    = vq3_reg;
        word_next.sin_v = neg_s3_reg ? -smag : smag;
        word_next.cos_v = neg_c3_reg ? -cmag : cmag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            elec1_reg   <= elec_prod[ANGLE_W-1:0];
            vd1_reg     <= volt_d;
            vq1_reg     <= volt_q;
            addr_s2_reg <= addr_s_next;
            addr_c2_reg <= addr_c_next;
            neg_s2_reg  <= quad_s[1];
            neg_c2_reg  <= quad_c[1];
            elec2_reg   <= elec1_reg;
            vd2_reg     <= vd1_reg;
            vq2_reg     <= vq1_reg;
            mag_s3_reg  <= SINE_ROM[addr_s2_reg];
            mag_c3_reg  <= SINE_ROM[addr_c2_reg];
            neg_s3_reg  <= neg_s2_reg;
            neg_c3_reg  <= neg_c2_reg;
            elec3_reg   <= elec2_reg;
            vd3_reg     <= vd2_reg;
            vq3_reg     <= vq2_reg;
            word4_reg   <= word_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_word  = word4_reg;

endmodule

// ===== hdl/fips_park.sv =====
// ============================================================================
// fips_park
// Inverse Park transform with round-half-up, then the sqrt(3) products.
// ============================================================================
module fips_park (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  fips_pkg::trig_word_t  in_word,
    output logic                  out_valid,
    output fips_pkg::park_word_t  out_word
);
    import fips_pkg::*;

    logic [2:0] v_reg;

    // stage 1: four products
    logic signed [PROD_W-1:0] cvd1_reg, svq1_reg, svd1_reg, cvq1_reg;
    logic [ANGLE_W-1:0]       elec1_reg;

    // stage 2: alpha / beta
    logic signed [PROD_W:0]   sum_a, sum_b;
    logic signed [AL_W-1:0]   al2_reg, bt2_reg;
    logic [ANGLE_W-1:0]       elec2_reg;

    assign sum_a = 34'(cvd1_reg) - 34'(svq1_reg) + 34'sd16384;
    assign sum_b = 34'(svd1_reg) + 34'(cvq1_reg) + 34'sd16384;

    // stage 3: sqrt(3) products and 3*alpha
    park_word_t word_next, word3_reg;

    always_comb begin
        word_next.elec = elec2_reg;
        word_next.bt   = bt2_reg;
        word_next.a3   = (A3_W'(al2_reg) <<< 1) + A3_W'(al2_reg);
        word_next.sa   = SP_W'(SQRT3_Q16) * SP_W'(al2_reg);
        word_next.sb   = SP_W'(SQRT3_Q16) * SP_W'(bt2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cvd1_reg  <= PROD_W'(in_word.cos_v) * PROD_W'(in_word.vd);
            svq1_reg  <= PROD_W'(in_word.sin_v) * PROD_W'(in_word.vq);
            svd1_reg  <= PROD_W'(in_word.sin_v) * PROD_W'(in_word.vd);
            cvq1_reg  <= PROD_W'(in_word.cos_v) * PROD_W'(in_word.vq);
            elec1_reg <= in_word.elec;
            al2_reg   <= AL_W'(sum_a >>> 15);
            bt2_reg   <= AL_W'(sum_b >>> 15);
            elec2_reg <= elec1_reg;
            word3_reg <= word_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_word  = word3_reg;

endmodule

// ===== hdl/fips_sector.sv =====
// ============================================================================
// fips_sector
// Sector code, X/Y/Z terms, phase numerators and the period scaling.
// ============================================================================
module fips_sector (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  fips_pkg::park_word_t        in_word,
    input  logic [fips_pkg::CMP_W-1:0]  supply_eff,
    input  logic [fips_pkg::CMP_W-1:0]  period,
    output logic                        out_valid,
    output fips_pkg::div_in_t           out_word
);
    import fips_pkg::*;

    logic [4:0] v_reg;

    // stage 1: code and X/Y/Z
    logic signed [NUM_W-1:0] btw, saw, sbw, a3w;
    logic [CODE_W-1:0]       code_next, code1_reg;
    logic signed [NUM_W-1:0] x1_reg, y1_reg, z1_reg;
    logic [ANGLE_W-1:0]      elec1_reg;

    assign btw = NUM_W'(in_word.bt) <<< 16;
    assign saw = NUM_W'(in_word.sa);
    assign sbw = NUM_W'(in_word.sb);
    assign a3w = NUM_W'(in_word.a3) <<< 16;

    assign code_next = {btw < -saw, btw < saw, in_word.bt > 0};

    // stage 2: phase numerators, permuted per sector
    logic signed [NUM_W-1:0] base, n1, n2, ha, hb, hc;
    logic [LANES-1:0][NUM_W-1:0] h_next, h2_reg;
    logic [CODE_W-1:0]       code_map, code2_reg;
    logic [ANGLE_W-1:0]      elec2_reg;

    assign base = $signed(NUM_W'({supply_eff, 17'b0}));

    always_comb begin
        code_map = code1_reg;
        case (code1_reg)
            SEC3: begin n1 = -z1_reg; n2 = x1_reg;  end
            SEC1: begin n1 = z1_reg;  n2 = y1_reg;  end
            SEC5: begin n1 = x1_reg;  n2 = -y1_reg; end
            SEC4: begin n1 = -x1_reg; n2 = z1_reg;  end
            SEC6: begin n1 = -y1_reg; n2 = -z1_reg; end
            default: begin
                n1 = y1_reg;
                n2 = -x1_reg;
                code_map = SEC2;
            end
        endcase
        ha = base + n1 + n2;
        hb = base - n1 + n2;
        hc = base - n1 - n2;
        case (code_map)
            SEC3:    h_next = {hc, hb, ha};
            SEC1:    h_next = {hc, ha, hb};
            SEC5:    h_next = {hb, ha, hc};
            SEC4:    h_next = {ha, hb, hc};
            SEC6:    h_next = {ha, hc, hb};
            default: h_next = {hb, hc, ha};
        endcase
    end

    // stage 3: sign and magnitude
    logic [LANES-1:0]             neg3_reg;
    logic [LANES-1:0][MAGN_W-1:0] mag3_reg;
    logic [CODE_W-1:0]            code3_reg;
    logic [ANGLE_W-1:0]           elec3_reg;

    // stage 4: magnitude times period, two partial products
    logic [LANES-1:0][35:0]       lo4_reg;
    logic [LANES-1:0][34:0]       hi4_reg;
    logic [LANES-1:0]             neg4_reg;
    logic [CODE_W-1:0]            code4_reg;
    logic [ANGLE_W-1:0]           elec4_reg;

    // stage 5: sum, drop the 2^18 part of the divisor
    div_in_t     word_next, word5_reg;
    logic [55:0] full [LANES];

    always_comb begin
        word_next.elec = elec4_reg;
        word_next.code = code4_reg;
        word_next.neg  = neg4_reg;
        for (int l = 0; l < LANES; l++) begin
            full[l] = (56'(hi4_reg[l]) << LO_W) + 56'(lo4_reg[l]);
            word_next.num[l] = full[l][54:18];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            code1_reg <= code_next;
            x1_reg    <= sbw <<< 1;
            y1_reg    <= a3w + sbw;
            z1_reg    <= sbw - a3w;
            elec1_reg <= in_word.elec;
            h2_reg    <= h_next;
            code2_reg <= code_map;
            elec2_reg <= elec1_reg;
            for (int l = 0; l < LANES; l++) begin
                neg3_reg[l] <= h2_reg[l][NUM_W-1];
                mag3_reg[l] <= h2_reg[l][NUM_W-1] ? MAGN_W'(-$signed(h2_reg[l]))
                                                  : MAGN_W'(h2_reg[l]);
                lo4_reg[l]  <= 36'(mag3_reg[l][LO_W-1:0]) * 36'(period);
                hi4_reg[l]  <= 35'(mag3_reg[l][MAGN_W-1:LO_W]) * 35'(period);
            end
            code3_reg <= code2_reg;
            elec3_reg <= elec2_reg;
            neg4_reg  <= neg3_reg;
            code4_reg <= code3_reg;
            elec4_reg <= elec3_reg;
            word5_reg <= word_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_word  = word5_reg;

endmodule

// ===== hdl/fips_div.sv =====
// ============================================================================
// fips_div
// Three-lane restoring divider by the bus voltage, one quotient bit a stage,
// with a range check up front that flags quotients of 2^17 and more.
// ============================================================================
module fips_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  fips_pkg::div_in_t           in_word,
    input  logic [fips_pkg::CMP_W-1:0]  divisor,
    output logic                        out_valid,
    output fips_pkg::div_word_t         out_word
);
    import fips_pkg::*;

    logic [QUO_W:0] v_reg;
    div_word_t      st_reg [0:QUO_W];
    div_word_t      st0_next;

    always_comb begin
        st0_next.elec = in_word.elec;
        st0_next.code = in_word.code;
        st0_next.neg  = in_word.neg;
        st0_next.quo  = '0;
        for (int l = 0; l < LANES; l++) begin
            st0_next.ovf[l] = in_word.num[l][DIVD_W-1:QUO_W] >= 20'(divisor);
            st0_next.rem[l] = in_word.num[l][REM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QUO_W-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_step
        localparam int B = QUO_W - j;
        div_word_t        st_next;
        logic [REM_W:0]   dsr;
        logic [REM_W:0]   trial;

        assign dsr = (REM_W + 1)'(divisor) << B;

        always_comb begin
            st_next = st_reg[j-1];
            for (int l = 0; l < LANES; l++) begin
                trial = {1'b0, st_reg[j-1].rem[l]} - dsr;
                if (!trial[REM_W]) begin
                    st_next.rem[l]    = trial[REM_W-1:0];
                    st_next.quo[l][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j] <= st_next;
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign out_word  = st_reg[QUO_W];

endmodule

// ===== hdl/foc_inverse_park_svpwm_core.sv =====
// ============================================================================
// foc_inverse_park_svpwm_core
// Encoder angle and d/q voltage to three clamped SVPWM compare values.
// ============================================================================
// Throughput: one word per cycle while the skid slot is free; the
//   17-stage quotient pipeline by the bus voltage is the longest part,
//   all stages advance together.
// Reset: aresetn is synchronous, active low; it clears all valid bits and
//   the skid slot and loads the register defaults. No table clearing pass.
module foc_inverse_park_svpwm_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input word: raw_angle[11:0], volt_d[27:12], volt_q[43:28], zero fill
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fips_pkg::IN_W-1:0]      s_tdata,
    // result word: compare_a[15:0], compare_b[31:16], compare_c[47:32],
    // sector_code[50:48], electrical_angle[62:51], clamped[63]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fips_pkg::OUT_W-1:0]     m_tdata,
    // register write port
    input  logic                           cfg_wr_en,
    input  logic [fips_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [fips_pkg::CFG_DW-1:0]    cfg_data
);
    import fips_pkg::*;

    // ---------------- configuration registers ----------------
    logic [ANGLE_W-1:0] enc_zero_reg;
    logic [PP_W-1:0]    pole_pairs_reg;
    logic [CMP_W-1:0]   supply_reg;
    logic [CMP_W-1:0]   period_reg;
    logic [CMP_W-1:0]   supply_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_zero_reg   <= ENC_ZERO_RST;
            pole_pairs_reg <= POLE_PAIRS_RST;
            supply_reg     <= SUPPLY_RST;
            period_reg     <= PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENC_ZERO:   enc_zero_reg   <= cfg_data[ANGLE_W-1:0];
                CFG_POLE_PAIRS: pole_pairs_reg <= cfg_data[PP_W-1:0];
                CFG_SUPPLY:     supply_reg     <= cfg_data;
                CFG_PERIOD:     period_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero bus voltage behaves as the smallest nonzero value
    assign supply_eff = (supply_reg == '0) ? CMP_W'(1) : supply_reg;

    // ---------------- pipeline ----------------
    // The whole pipeline moves while the skid slot is free, so s_tready
    // comes from a flop and never from m_tready.
    logic        en;
    logic        spare_valid_reg;
    logic        trig_valid, park_valid, sect_valid, div_valid;
    trig_word_t  trig_word;
    park_word_t  park_word;
    div_in_t     sect_word;
    div_word_t   div_word;

    assign en       = !spare_valid_reg;
    assign s_tready = en;

    fips_trig u_trig (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .raw_angle    (s_tdata[11:0]),
        .volt_d       ($signed(s_tdata[27:12])),
        .volt_q       ($signed(s_tdata[43:28])),
        .encoder_zero (enc_zero_reg),
        .pole_pairs   (pole_pairs_reg),
        .out_valid    (trig_valid),
        .out_word     (trig_word)
    );

    fips_park u_park (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (trig_valid),
        .in_word   (trig_word),
        .out_valid (park_valid),
        .out_word  (park_word)
    );

    fips_sector u_sector (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (park_valid),
        .in_word    (park_word),
        .supply_eff (supply_eff),
        .period     (period_reg),
        .out_valid  (sect_valid),
        .out_word   (sect_word)
    );

    fips_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sect_valid),
        .in_word   (sect_word),
        .divisor   (supply_eff),
        .out_valid (div_valid),
        .out_word  (div_word)
    );

    // ---------------- clamp to 0..period ----------------
    // Negative numerators truncate toward zero: a zero quotient is a plain
    // zero, anything else is overmodulation.
    logic [LANES-1:0][CMP_W-1:0] cmp;
    logic [LANES-1:0]            lane_cl;
    logic [OUT_W-1:0]            result_next;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (div_word.neg[l]) begin
                cmp[l]     = '0;
                lane_cl[l] = div_word.ovf[l] || (div_word.quo[l] != '0);
            end else if (div_word.ovf[l] || (div_word.quo[l] > QUO_W'(period_reg))) begin
                cmp[l]     = period_reg;
                lane_cl[l] = 1'b1;
            end else begin
                cmp[l]     = div_word.quo[l][CMP_W-1:0];
                lane_cl[l] = 1'b0;
            end
        end
        result_next = {|lane_cl, div_word.elec, div_word.code, cmp[2], cmp[1], cmp[0]};
    end

    // ---------------- output register plus skid slot ----------------
    logic             push;
    logic [OUT_W-1:0] out_reg, spare_reg;
    logic             out_valid_reg;

    assign push = en && div_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (spare_valid_reg) begin
                out_valid_reg   <= 1'b1;
                spare_valid_reg <= 1'b0;
            end else begin
                out_valid_reg   <= push;
            end
        end else if (push) begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= spare_valid_reg ? spare_reg : result_next;
        end else if (push) begin
            spare_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== hdl/fips_checker.sv =====
// ============================================================================
// fips_checker
// Port-level checks on the inverse Park / SVPWM core, bound to the top.
// ============================================================================
module fips_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [fips_pkg::OUT_W-1:0]  m_tdata
);
    import fips_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // zero vector and code 7 fold into sector two
    a_sector: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[50:48] != 3'd0) && (m_tdata[50:48] != 3'd7))
        else $error("sector code out of range");

    // reset empties the output side
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty after reset");

    // input side stays open while the output is drained every cycle
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready && $past(m_tready) && $past(aresetn) |-> s_tready)
        else $error("input stalled with a free output");

endmodule

bind foc_inverse_park_svpwm_core fips_checker u_fips_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/foc_inverse_park_svpwm_core_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// foc_inverse_park_svpwm_core_tb
// Self-checking bench: directed table at reset defaults, then random words
// under several register settings, checked against an in-bench predictor.
// ============================================================================
module foc_inverse_park_svpwm_core_tb;
    import fips_pkg::*;

    localparam int       PERIOD_NS   = 20;
    localparam int       PIPE_DEPTH  = 30;
    localparam longint   CYCLE_LIMIT = 400000;
    localparam int       RAND_PER_PH = 65;

    typedef struct {
        logic [CMP_W-1:0]   cmp_a;
        logic [CMP_W-1:0]   cmp_b;
        logic [CMP_W-1:0]   cmp_c;
        logic [CODE_W-1:0]  sector;
        logic [ANGLE_W-1:0] elec;
        logic               clamped;
    } pwm_result_t;

    typedef struct {
        logic [ANGLE_W-1:0]       raw;
        logic signed [VOLT_W-1:0] vd;
        logic signed [VOLT_W-1:0] vq;
        bit                       typed;   // expected result given in the row
        pwm_result_t              res;
    } directed_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_wr_en;
    logic [CFG_AW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;

    // bench copy of the register file
    logic [11:0] enc_zero_q;
    logic [5:0]  pole_pairs_q;
    logic [15:0] supply_q;
    logic [15:0] period_q;

    longint      sine_lut [0:ROM_DEPTH-1];
    pwm_result_t pending_pwm [$];
    // typed expectations ride alongside; flag says whether to use them
    bit          pending_typed [$];
    pwm_result_t pending_typed_res [$];
    bit          typed_next;
    pwm_result_t typed_next_res;

    int          mismatches = 0;
    longint      cycles = 0;

    foc_inverse_park_svpwm_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(PERIOD_NS / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Quarter-wave sine, Q30 Taylor series with eight correction terms, rounded to Q1.15.
    task automatic fill_sine_lut();
        longint unsigned x, x2, term;
        longint          acc, rnd;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            x    = (longint'(i) * HALF_PI_Q30) >> 10;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2) acc -= longint'(term);
                else       acc += longint'(term);
            end
            if (acc < 0) acc = 0;
            rnd = (acc + 64'sd16384) >>> 15;
            if (rnd > 32768) rnd = 32768;
            sine_lut[i] = rnd;
        end
    endtask

    function automatic longint sine_at(logic [ANGLE_W-1:0] ang);
        logic [1:0] quad;
        int         idx;
        longint     mag;
        quad = ang[11:10];
        idx  = int'(ang[9:0]);
        mag  = quad[0] ? sine_lut[1024 - idx] : sine_lut[idx];
        return quad[1] ? -mag : mag;
    endfunction

    // Truncate toward zero, then clamp to 0..Ts.
    function automatic logic [CMP_W-1:0] tick_clamp(longint num, longint den2,
                                                   longint ts, inout logic cl);
        longint q;
        q = num / den2;
        if (q < 0) begin
            cl = 1'b1;
            return '0;
        end
        if (q > ts) begin
            cl = 1'b1;
            return ts[CMP_W-1:0];
        end
        return q[CMP_W-1:0];
    endfunction

    function automatic pwm_result_t predict_pwm(logic [ANGLE_W-1:0] raw,
                                                logic signed [VOLT_W-1:0] vd,
                                                logic signed [VOLT_W-1:0] vq);
        pwm_result_t      r;
        logic [ANGLE_W-1:0] mech, elec;
        logic [17:0]      prod;
        longint           sn, cs, al, bt, u, ts, den, base, sq3;
        longint           nx, ny, nz, n1, n2, ha, hb, hc, ca, cb, cc;
        logic [CODE_W-1:0] sec;
        logic             cl;
        mech = raw - enc_zero_q;
        prod = pole_pairs_q * mech;
        elec = prod[ANGLE_W-1:0];
        sn   = sine_at(elec);
        cs   = sine_at(elec + 12'd1024);
        al   = (cs * longint'(vd) - sn * longint'(vq) + 64'sd16384) >>> 15;
        bt   = (sn * longint'(vd) + cs * longint'(vq) + 64'sd16384) >>> 15;
        u    = (supply_q == 0) ? 1 : longint'(supply_q);
        ts   = longint'(period_q);
        den  = 2 * u * 65536;
        sq3  = longint'(SQRT3_Q16);

        sec = 3'd0;
        if (bt * 65536 < -sq3 * al) sec += 3'd4;
        if (bt * 65536 <  sq3 * al) sec += 3'd2;
        if (bt > 0)                 sec += 3'd1;

        nx = 2 * sq3 * bt * ts;
        ny = ts * ( 3 * al * 65536 + sq3 * bt);
        nz = ts * (-3 * al * 65536 + sq3 * bt);

        case (sec)
            SEC3:    begin n1 = -nz; n2 =  nx; end
            SEC1:    begin n1 =  nz; n2 =  ny; end
            SEC5:    begin n1 =  nx; n2 = -ny; end
            SEC4:    begin n1 = -nx; n2 =  nz; end
            SEC6:    begin n1 = -ny; n2 = -nz; end
            default: begin n1 =  ny; n2 = -nx; sec = SEC2; end  // zero vector too
        endcase

        base = ts * den;
        ha = base + n1 + n2;
        hb = base - n1 + n2;
        hc = base - n1 - n2;
        case (sec)
            SEC3:    begin ca = ha; cb = hb; cc = hc; end
            SEC1:    begin ca = hb; cb = ha; cc = hc; end
            SEC5:    begin ca = hc; cb = ha; cc = hb; end
            SEC4:    begin ca = hc; cb = hb; cc = ha; end
            SEC6:    begin ca = hb; cb = hc; cc = ha; end
            default: begin ca = ha; cb = hc; cc = hb; end
        endcase

        cl = 1'b0;
        r.cmp_a   = tick_clamp(ca, 2 * den, ts, cl);
        r.cmp_b   = tick_clamp(cb, 2 * den, ts, cl);
        r.cmp_c   = tick_clamp(cc, 2 * den, ts, cl);
        r.sector  = sec;
        r.elec    = elec;
        r.clamped = cl;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: every accepted word gets its expected result queued.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            pending_pwm.push_back(predict_pwm(s_tdata[11:0], s_tdata[27:12],
                                              s_tdata[43:28]));
            pending_typed.push_back(typed_next);
            pending_typed_res.push_back(typed_next_res);
        end
    end

    // ------------------------------------------------------------------------
    // Result side: compare against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        pwm_result_t got, want;
        bit          use_typed;
        pwm_result_t typed_res;
        if (aresetn && m_tvalid && m_tready) begin
            got.cmp_a   = m_tdata[15:0];
            got.cmp_b   = m_tdata[31:16];
            got.cmp_c   = m_tdata[47:32];
            got.sector  = m_tdata[50:48];
            got.elec    = m_tdata[62:51];
            got.clamped = m_tdata[63];
            if (pending_pwm.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", m_tdata);
            end else begin
                want      = pending_pwm.pop_front();
                use_typed = pending_typed.pop_front();
                typed_res = pending_typed_res.pop_front();
                if (use_typed) want = typed_res;
                if (got.cmp_a !== want.cmp_a || got.cmp_b !== want.cmp_b ||
                    got.cmp_c !== want.cmp_c || got.sector !== want.sector ||
                    got.elec !== want.elec || got.clamped !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp a=%0d b=%0d c=%0d sec=%0d el=%0d cl=%0d",
                                 want.cmp_a, want.cmp_b, want.cmp_c, want.sector,
                                 want.elec, want.clamped);
                        $display("         got a=%0d b=%0d c=%0d sec=%0d el=%0d cl=%0d",
                                 got.cmp_a, got.cmp_b, got.cmp_c, got.sector,
                                 got.elec, got.clamped);
                    end
                end
            end
        end
    end

    // Receiver back-pressure in one of four randomly picked modes.
    always @(posedge aclk) begin
        int ready_mode;
        if (cycles % 32 == 0) ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0:       m_tready <= 1'b1;                       // no stall
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 7) == 0); // heavy stall
            default: m_tready <= (cycles % 3 != 0);
        endcase
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    int burst_left;

    // Present one word and hold until accepted; gaps fall between bursts.
    task automatic send_word(logic [ANGLE_W-1:0] raw, logic signed [VOLT_W-1:0] vd,
                             logic signed [VOLT_W-1:0] vq);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, vq, vd, raw};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pwm.size() != 0) @(posedge aclk);
    endtask

    task automatic write_regs(logic [11:0] zero, logic [5:0] pp,
                              logic [15:0] vbus, logic [15:0] per);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ENC_ZERO;   cfg_data <= {4'b0, zero}; @(posedge aclk);
        cfg_index <= CFG_POLE_PAIRS; cfg_data <= {10'b0, pp};  @(posedge aclk);
        cfg_index <= CFG_SUPPLY;     cfg_data <= vbus;         @(posedge aclk);
        cfg_index <= CFG_PERIOD;     cfg_data <= per;          @(posedge aclk);
        cfg_wr_en <= 1'b0;
        enc_zero_q   = zero;
        pole_pairs_q = pp;
        supply_q     = vbus;
        period_q     = per;
        @(posedge aclk);
    endtask

    function automatic logic signed [VOLT_W-1:0] rand_volt();
        case ($urandom_range(0, 3))
            0:       return $signed(16'($urandom_range(0, 65535)));   // full range
            1:       return $signed(16'($urandom_range(0, 511))) - 16'sd256;
            default: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    directed_row_t dir_rows [$];
    logic [15:0]   phase_cfg [0:5][0:3];

    initial begin
        directed_row_t row;
        pwm_result_t   zero_res;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_ENC_ZERO;
        cfg_data   = '0;
        burst_left = 0;
        typed_next = 1'b0;
        typed_next_res = '{default: '0};
        enc_zero_q   = ENC_ZERO_RST;
        pole_pairs_q = POLE_PAIRS_RST;
        supply_q     = SUPPLY_RST;
        period_q     = PERIOD_RST;
        fill_sine_lut();

        // zero vector at reset defaults: all three at Ts/2, reported as sector 2
        zero_res = '{cmp_a: 16'd900, cmp_b: 16'd900, cmp_c: 16'd900,
                     sector: SEC2, elec: 12'd0, clamped: 1'b0};
        row = '{raw: 12'd0, vd: 16'sd0, vq: 16'sd0, typed: 1'b1, res: zero_res};
        dir_rows.push_back(row);
        zero_res.elec = 12'd4089;                 // 7 * 4095 wrapped
        row.raw = 12'd4095; row.res = zero_res;
        dir_rows.push_back(row);

        row.typed = 1'b0;
        // voltage extremes, both axes, both signs
        row.raw = 12'd0;    row.vd = 16'sd32767;  row.vq = 16'sd0;      dir_rows.push_back(row);
        row.raw = 12'd0;    row.vd = -16'sd32768; row.vq = 16'sd0;      dir_rows.push_back(row);
        row.raw = 12'd0;    row.vd = 16'sd0;      row.vq = 16'sd32767;  dir_rows.push_back(row);
        row.raw = 12'd0;    row.vd = 16'sd0;      row.vq = -16'sd32768; dir_rows.push_back(row);
        row.raw = 12'd4095; row.vd = 16'sd32767;  row.vq = 16'sd32767;  dir_rows.push_back(row);
        row.raw = 12'd2048; row.vd = -16'sd32768; row.vq = -16'sd32768; dir_rows.push_back(row);
        row.raw = 12'd1;    row.vd = 16'sd1;      row.vq = -16'sd1;     dir_rows.push_back(row);
        // walk the angle so each sector is visited at modest voltage
        for (int i = 0; i < 12; i++) begin
            row.raw = 12'(i * 49);
            row.vd  = 16'sd200;
            row.vq  = 16'sd1000;
            dir_rows.push_back(row);
        end

        // register settings: low extremes, high extremes, out-of-range, fixed, random
        phase_cfg[0] = '{16'd0,    16'd1,  16'd1,     16'd2};
        phase_cfg[1] = '{16'd4095, 16'd32, 16'd65535, 16'd65535};
        phase_cfg[2] = '{16'd0,    16'd0,  16'd0,     16'd0};
        phase_cfg[3] = '{16'd100,  16'd63, 16'd3072,  16'd1800};
        phase_cfg[4] = '{16'($urandom_range(0, 4095)), 16'($urandom_range(1, 32)),
                         16'($urandom_range(256, 12000)), 16'($urandom_range(2, 65535))};
        phase_cfg[5] = '{16'($urandom_range(0, 4095)), 16'($urandom_range(1, 32)),
                         16'($urandom_range(1, 65535)), 16'($urandom_range(2, 4000))};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset defaults; the typed flag moves with the word
        foreach (dir_rows[i]) begin
            typed_next     <= dir_rows[i].typed;
            typed_next_res <= dir_rows[i].res;
            send_word(dir_rows[i].raw, dir_rows[i].vd, dir_rows[i].vq);
        end
        typed_next <= 1'b0;
        drain();

        // random part under each register setting
        for (int p = 0; p < 6; p++) begin
            write_regs(phase_cfg[p][0][11:0], phase_cfg[p][1][5:0],
                       phase_cfg[p][2], phase_cfg[p][3]);
            for (int n = 0; n < RAND_PER_PH; n++)
                send_word(12'($urandom_range(0, 4095)), rand_volt(), rand_volt());
            drain();
        end

        repeat (PIPE_DEPTH + 10) @(posedge aclk);
        if (mismatches == 0 && pending_pwm.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
